@@ hdl/mtfc_pkg.sv @@
// Shared types and constants of the Modbus/TCP frame checker.
// Used by mtfc_parser, mtfc_checker and modbus_tcp_frame_checker.
package mtfc_pkg;

    localparam int unsigned CFG_INDEX_BITS = 8;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_WATCHED = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CEILING = 8'd1;

    localparam logic [15:0] WATCHED_RESET = 16'h0001;
    localparam logic [15:0] CEILING_RESET = 16'd3000;

    localparam logic [7:0]  WRITE_SINGLE    = 8'h06;
    localparam logic [15:0] PROTOCOL_MODBUS = 16'h0000;
    localparam logic [3:0]  HEADER_BYTES    = 4'd8;
    localparam logic [3:0]  WRITE_BYTES     = 4'd12;

    // Parse status codes.
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_SHORT       = 2'd1;
    localparam logic [1:0] ST_BAD_PROTO   = 2'd2;
    localparam logic [1:0] ST_SHORT_WRITE = 2'd3;

    // Assessment codes.
    localparam logic [1:0] AS_NONE       = 2'd0;
    localparam logic [1:0] AS_OK         = 2'd1;
    localparam logic [1:0] AS_SUSPICIOUS = 2'd2;

    localparam int unsigned OUT_BITS = 180;
    localparam int unsigned OUT_DATA_BITS = 184;

    typedef struct packed {
        logic [15:0] transaction;
        logic [15:0] protocol;
        logic [15:0] length;
        logic [7:0]  unit;
        logic [7:0]  code;
        logic [15:0] address;
        logic [15:0] value;
        logic [3:0]  count;
    } t_frame;

    typedef struct packed {
        logic [15:0] watched;
        logic [15:0] ceiling;
    } t_cfg;

endpackage

@@ hdl/mtfc_parser.sv @@
// Byte parser: places each byte into the MBAP and PDU field registers and
// holds a snapshot of the fields at frame end. Depends on mtfc_pkg.
module mtfc_parser
    import mtfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output logic       o_frame_vld,
    output t_frame     o_frame,
    input  logic       i_take
);

    logic [3:0]  r_pos;
    logic [15:0] r_tx, r_proto, r_len, r_addr, r_val;
    logic [7:0]  r_unit, r_code;
    logic        r_snap_vld;
    t_frame      r_snap;

    logic [15:0] n_tx, n_proto, n_len, n_addr, n_val;
    logic [7:0]  n_unit, n_code;
    logic [3:0]  n_count;
    logic        accept;

    assign o_ready = !r_snap_vld || i_take;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_tx    = r_tx;
        n_proto = r_proto;
        n_len   = r_len;
        n_unit  = r_unit;
        n_code  = r_code;
        n_addr  = r_addr;
        n_val   = r_val;
        case (r_pos) inside
            4'd0, 4'd1:   n_tx    = {r_tx[7:0], i_byte};
            4'd2, 4'd3:   n_proto = {r_proto[7:0], i_byte};
            4'd4, 4'd5:   n_len   = {r_len[7:0], i_byte};
            4'd6:         n_unit  = i_byte;
            4'd7:         n_code  = i_byte;
            4'd8, 4'd9:   n_addr  = {r_addr[7:0], i_byte};
            4'd10, 4'd11: n_val   = {r_val[7:0], i_byte};
            default: ;
        endcase
        // The position stops at twelve; later bytes change nothing.
        n_count = (r_pos >= WRITE_BYTES) ? WRITE_BYTES : r_pos + 4'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_tx       <= '0;
            r_proto    <= '0;
            r_len      <= '0;
            r_unit     <= '0;
            r_code     <= '0;
            r_addr     <= '0;
            r_val      <= '0;
            r_snap_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_pos   <= i_last ? 4'd0 : n_count;
                r_tx    <= n_tx;
                r_proto <= n_proto;
                r_len   <= n_len;
                r_unit  <= n_unit;
                r_code  <= n_code;
                r_addr  <= n_addr;
                r_val   <= n_val;
            end
            if (accept && i_last) begin
                r_snap_vld <= 1'b1;
            end else if (i_take) begin
                r_snap_vld <= 1'b0;
            end
        end
    end

    // The snapshot is taken from the next-state values so the following
    // frame may start in the very next cycle.
    always_ff @(posedge i_clk) begin
        if (accept && i_last) begin
            r_snap.transaction <= n_tx;
            r_snap.protocol    <= n_proto;
            r_snap.length      <= n_len;
            r_snap.unit        <= n_unit;
            r_snap.code        <= n_code;
            r_snap.address     <= n_addr;
            r_snap.value       <= n_val;
            r_snap.count       <= n_count;
        end
    end

    assign o_frame_vld = r_snap_vld;
    assign o_frame     = r_snap;

endmodule

@@ hdl/mtfc_checker.sv @@
// Frame checker: derives status and assessment, keeps the saturating
// counters and holds the result register. Depends on mtfc_pkg.
module mtfc_checker
    import mtfc_pkg::*;
#(
    parameter int unsigned COUNT_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_frame_vld,
    input  t_frame                   i_frame,
    output logic                     o_take,
    input  t_cfg                     i_cfg,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [OUT_DATA_BITS-1:0] o_data
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    logic [COUNT_BITS-1:0] r_total, r_susp, r_malf;
    logic [COUNT_BITS-1:0] n_total, n_susp, n_malf;
    logic                  r_out_vld;
    logic [OUT_BITS-1:0]   r_out;

    logic [15:0] n_tx, n_len, n_addr, n_val;
    logic [7:0]  n_unit, n_code;
    logic [1:0]  n_status, n_assess;
    logic [63:0] w_total, w_susp, w_malf;

    assign o_take = i_frame_vld && (!r_out_vld || i_ready);

    always_comb begin
        n_tx     = '0;
        n_len    = '0;
        n_unit   = '0;
        n_code   = '0;
        n_addr   = '0;
        n_val    = '0;
        n_status = ST_OK;
        n_assess = AS_NONE;
        if (i_frame.count < HEADER_BYTES) begin
            n_status = ST_SHORT;
        end else begin
            n_tx   = i_frame.transaction;
            n_len  = i_frame.length;
            n_unit = i_frame.unit;
            n_code = i_frame.code;
            if (i_frame.protocol != PROTOCOL_MODBUS) begin
                n_status = ST_BAD_PROTO;
            end else if (i_frame.code == WRITE_SINGLE) begin
                if (i_frame.count < WRITE_BYTES) begin
                    n_status = ST_SHORT_WRITE;
                end else begin
                    n_addr = i_frame.address;
                    n_val  = i_frame.value;
                    if (i_frame.address == i_cfg.watched) begin
                        n_assess = (i_frame.value > i_cfg.ceiling) ? AS_SUSPICIOUS : AS_OK;
                    end
                end
            end
        end

        n_total = (r_total == CNT_MAX) ? r_total : r_total + CNT_ONE;
        n_susp  = r_susp;
        n_malf  = r_malf;
        if (n_assess == AS_SUSPICIOUS && r_susp != CNT_MAX) begin
            n_susp = r_susp + CNT_ONE;
        end
        if (n_status != ST_OK && r_malf != CNT_MAX) begin
            n_malf = r_malf + CNT_ONE;
        end

        // Counters are reported as their low 32 bits.
        w_total = 64'(n_total);
        w_susp  = 64'(n_susp);
        w_malf  = 64'(n_malf);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= '0;
            r_susp    <= '0;
            r_malf    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_take) begin
                r_total   <= n_total;
                r_susp    <= n_susp;
                r_malf    <= n_malf;
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out <= {w_malf[31:0], w_susp[31:0], w_total[31:0], n_assess, n_status,
                      n_val, n_addr, n_code, n_unit, n_len, n_tx};
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = {{(OUT_DATA_BITS - OUT_BITS){1'b0}}, r_out};

endmodule

@@ hdl/modbus_tcp_frame_checker.sv @@
// Top level of the Modbus/TCP frame checker: configuration registers and
// the parser and checker stages. Depends on mtfc_pkg, mtfc_parser, mtfc_checker.
//
// The block takes one frame byte per clock with tlast on the final byte and
// gives one result per frame. A byte can be taken every cycle, back to back
// across frame ends; the result is registered in the snapshot register and
// then in the output register, where it is held until it is taken. The
// snapshot register between the parser and the checker holds one finished
// frame, so the input stalls, for any byte, while that snapshot and the output
// register are both full and the downstream side is not ready.
// Configuration writes are always accepted and take effect on the next frame
// end evaluated; writes to unknown indexes are ignored.
module modbus_tcp_frame_checker
    import mtfc_pkg::*;
#(
    parameter int unsigned COUNT_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [7:0]                i_s_tdata,   // [7:0] frame_byte
    input  logic                      i_s_tlast,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    // [15:0] transaction, [31:16] length_field, [39:32] unit_id,
    // [47:40] pdu_code, [63:48] register_address, [79:64] write_value,
    // [81:80] parse_status, [83:82] assessment, [115:84] frame_count,
    // [147:116] suspicious_count, [179:148] malformed_count, [183:180] zero
    output logic [OUT_DATA_BITS-1:0]  o_m_tdata,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [15:0]               i_cfg_data
);

    t_cfg   r_cfg;
    t_frame frame;
    logic   frame_vld;
    logic   take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.watched <= WATCHED_RESET;
            r_cfg.ceiling <= CEILING_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_WATCHED: r_cfg.watched <= i_cfg_data;
                REG_CEILING: r_cfg.ceiling <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mtfc_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_byte      (i_s_tdata),
        .i_last      (i_s_tlast),
        .o_frame_vld (frame_vld),
        .o_frame     (frame),
        .i_take      (take)
    );

    mtfc_checker #(
        .COUNT_BITS (COUNT_BITS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_frame_vld (frame_vld),
        .i_frame     (frame),
        .o_take      (take),
        .i_cfg       (r_cfg),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_data      (o_m_tdata)
    );

endmodule

@@ dv/mtfc_frame_audit.sv @@
// Checker for the Modbus/TCP frame checker: watches the byte, result and
// configuration channels, predicts each frame report and compares it.
// Depends on mtfc_pkg for the register indexes, codes and result width.
module mtfc_frame_audit
    import mtfc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    input  logic                      i_s_tready,
    input  logic [7:0]                i_s_tdata,
    input  logic                      i_s_tlast,
    input  logic                      i_m_tvalid,
    input  logic                      i_m_tready,
    input  logic [OUT_DATA_BITS-1:0]  i_m_tdata,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [15:0]               i_cfg_data,
    output int unsigned               o_mismatches,
    output int unsigned               o_outstanding,
    output int unsigned               o_checked,
    output int unsigned               o_flagged
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] txn;
        logic [15:0] length;
        logic [7:0]  unit;
        logic [7:0]  code;
        logic [15:0] addr;
        logic [15:0] value;
        logic [1:0]  status;
        logic [1:0]  assess;
        logic [31:0] frames;
        logic [31:0] flagged;
        logic [31:0] malformed;
    } t_report;

    t_report     pending_reports[$];
    logic [15:0] watched;
    logic [15:0] ceiling;
    logic [3:0]  pos;
    logic [15:0] txn_sr;
    logic [15:0] proto_sr;
    logic [15:0] len_sr;
    logic [15:0] addr_sr;
    logic [15:0] val_sr;
    logic [7:0]  unit_r;
    logic [7:0]  code_r;
    logic [31:0] frames_n;
    logic [31:0] flagged_n;
    logic [31:0] malformed_n;
    int unsigned mismatches = 0;
    int unsigned checked = 0;
    int unsigned flagged_seen = 0;

    function automatic logic [31:0] bump(logic [31:0] c);
        return (c == '1) ? c : c + 32'd1;
    endfunction

    // Shifts one byte into the header image and, on the frame's last byte,
    // queues the report the block should give for it.
    task automatic decode_byte(input logic [7:0] b, input logic last);
        logic [3:0] seen;
        t_report    r;
        case (pos)
            4'd0, 4'd1:   txn_sr = {txn_sr[7:0], b};
            4'd2, 4'd3:   proto_sr = {proto_sr[7:0], b};
            4'd4, 4'd5:   len_sr = {len_sr[7:0], b};
            4'd6:         unit_r = b;
            4'd7:         code_r = b;
            4'd8, 4'd9:   addr_sr = {addr_sr[7:0], b};
            4'd10, 4'd11: val_sr = {val_sr[7:0], b};
            default: ;
        endcase
        seen = (pos >= WRITE_BYTES) ? WRITE_BYTES : pos + 4'd1;
        if (!last) begin
            pos = seen;
        end else begin
            pos = '0;
            r = '0;
            r.status = ST_OK;
            r.assess = AS_NONE;
            if (seen < HEADER_BYTES) begin
                r.status = ST_SHORT;
            end else begin
                r.txn = txn_sr;
                r.length = len_sr;
                r.unit = unit_r;
                r.code = code_r;
                if (proto_sr != PROTOCOL_MODBUS) begin
                    r.status = ST_BAD_PROTO;
                end else if (code_r == WRITE_SINGLE) begin
                    if (seen < WRITE_BYTES) begin
                        r.status = ST_SHORT_WRITE;
                    end else begin
                        r.addr = addr_sr;
                        r.value = val_sr;
                        if (addr_sr == watched)
                            r.assess = (val_sr > ceiling) ? AS_SUSPICIOUS : AS_OK;
                    end
                end
            end
            frames_n = bump(frames_n);
            if (r.assess == AS_SUSPICIOUS)
                flagged_n = bump(flagged_n);
            if (r.status != ST_OK)
                malformed_n = bump(malformed_n);
            r.frames = frames_n;
            r.flagged = flagged_n;
            r.malformed = malformed_n;
            pending_reports.push_back(r);
        end
    endtask

    task automatic flag(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
            flag($sformatf("%s expected %0h, got %0h", name, want, got));
    endtask

    task automatic check_report(input logic [OUT_DATA_BITS-1:0] d);
        t_report want;
        if (pending_reports.size() == 0) begin
            flag($sformatf("result %0h arrived with no frame pending", d));
        end else begin
            want = pending_reports.pop_front();
            checked++;
            if (d[83:82] == AS_SUSPICIOUS)
                flagged_seen++;
            compare_field("transaction", 32'(want.txn), 32'(d[15:0]));
            compare_field("length_field", 32'(want.length), 32'(d[31:16]));
            compare_field("unit_id", 32'(want.unit), 32'(d[39:32]));
            compare_field("pdu_code", 32'(want.code), 32'(d[47:40]));
            compare_field("register_address", 32'(want.addr), 32'(d[63:48]));
            compare_field("write_value", 32'(want.value), 32'(d[79:64]));
            compare_field("parse_status", 32'(want.status), 32'(d[81:80]));
            compare_field("assessment", 32'(want.assess), 32'(d[83:82]));
            compare_field("frame_count", want.frames, d[115:84]);
            compare_field("suspicious_count", want.flagged, d[147:116]);
            compare_field("malformed_count", want.malformed, d[179:148]);
            compare_field("padding", 32'd0, 32'(d[183:180]));
        end
    endtask

    // Within one edge the result is checked before a new frame end is queued,
    // since a result can never belong to the byte transferred at that edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            watched = WATCHED_RESET;
            ceiling = CEILING_RESET;
            pos = '0;
            txn_sr = '0;
            proto_sr = '0;
            len_sr = '0;
            addr_sr = '0;
            val_sr = '0;
            unit_r = '0;
            code_r = '0;
            frames_n = '0;
            flagged_n = '0;
            malformed_n = '0;
            pending_reports.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_WATCHED: watched = i_cfg_data;
                    REG_CEILING: ceiling = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready)
                check_report(i_m_tdata);
            if (i_s_tvalid && i_s_tready)
                decode_byte(i_s_tdata, i_s_tlast);
        end
        o_mismatches <= mismatches;
        o_outstanding <= pending_reports.size();
        o_checked <= checked;
        o_flagged <= flagged_seen;
    end

endmodule

@@ dv/tb_modbus_tcp_frame_checker.sv @@
// Top of the Modbus/TCP frame checker testbench: clock, reset, byte stream,
// result back-pressure and register writes. Depends on mtfc_pkg, the block
// and the mtfc_frame_audit checker, which predicts and compares the reports.
module tb_modbus_tcp_frame_checker;
    timeunit 1ns;
    timeprecision 1ps;

    import mtfc_pkg::*;

    localparam int unsigned STALL_LIMIT = 400;
    localparam int unsigned PHASE_BYTES = 85;
    localparam int unsigned PHASES = 5;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [7:0]                s_tdata = '0;
    logic                      s_tlast = 1'b0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0]  m_tdata;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [15:0]               cfg_data = '0;

    int unsigned audit_mismatches;
    int unsigned audit_outstanding;
    int unsigned audit_checked;
    int unsigned audit_flagged;

    logic [7:0]  frame_q[$];
    int unsigned bytes_sent = 0;
    int unsigned frames_sent = 0;
    int unsigned idle_cycles = 0;
    bit          tx_burst = 1'b0;
    bit          rx_burst = 1'b0;
    logic [15:0] cur_watched = WATCHED_RESET;
    logic [15:0] cur_ceiling = CEILING_RESET;

    always #6 clk = ~clk;

    modbus_tcp_frame_checker dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tlast   (s_tlast),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    mtfc_frame_audit audit (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tlast     (s_tlast),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (audit_mismatches),
        .o_outstanding (audit_outstanding),
        .o_checked     (audit_checked),
        .o_flagged     (audit_flagged)
    );

    function automatic int unsigned pick_gap(bit burst);
        return burst ? 0 : $urandom_range(0, 11);
    endfunction

    // Leaves tvalid high after the transfer so back-to-back bytes need no
    // second assignment in the same step.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        gap = pick_gap(tx_burst);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_q[i])
            send_byte(frame_q[i], i == frame_q.size() - 1);
        frame_q.delete();
        frames_sent++;
    endtask

    task automatic put_word(input logic [15:0] w);
        frame_q.push_back(w[15:8]);
        frame_q.push_back(w[7:0]);
    endtask

    task automatic put_junk(input int unsigned n);
        repeat (n) frame_q.push_back(8'($urandom));
    endtask

    task automatic put_header(input logic [15:0] txn, input logic [15:0] proto,
                              input logic [7:0] code);
        put_word(txn);
        put_word(proto);
        put_word(16'($urandom));
        frame_q.push_back(8'($urandom));
        frame_q.push_back(code);
    endtask

    task automatic put_write(input logic [15:0] txn, input logic [15:0] addr,
                             input logic [15:0] value, input int unsigned extra);
        put_header(txn, PROTOCOL_MODBUS, WRITE_SINGLE);
        put_word(addr);
        put_word(value);
        put_junk(extra);
        send_frame();
    endtask

    // Waits until every queued report has come back, plus the output latency.
    task automatic settle();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge clk);
        while (audit_outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_put(input logic [CFG_INDEX_BITS-1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_WATCHED)
            cur_watched = val;
        else if (idx == REG_CEILING)
            cur_ceiling = val;
    endtask

    task automatic reconfigure(input logic [15:0] watched, input logic [15:0] ceiling,
                               input bit with_unknown);
        settle();
        cfg_put(REG_WATCHED, watched);
        cfg_put(REG_CEILING, ceiling);
        if (with_unknown) begin
            cfg_put('1, 16'hFFFF);
            cfg_put(CFG_INDEX_BITS'($urandom_range(2, 254)), 16'($urandom));
        end
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed writes aimed at the watched register around the
    // ceiling; the rest are other codes, bad protocols and truncated frames.
    task automatic random_frame();
        int unsigned kind;
        logic [15:0] addr;
        logic [15:0] value;
        kind = $urandom_range(0, 99);
        tx_burst = ($urandom_range(0, 3) == 0);
        rx_burst = ($urandom_range(0, 3) == 0);
        if (kind < 55) begin
            addr = ($urandom_range(0, 2) != 0) ? cur_watched : 16'($urandom);
            case ($urandom_range(0, 4))
                0: value = cur_ceiling;
                1: value = cur_ceiling + 16'd1;
                2: value = cur_ceiling - 16'd1;
                3: value = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
                default: value = 16'($urandom);
            endcase
            put_write(16'($urandom), addr, value,
                      ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0);
        end else begin
            if (kind < 70) begin
                put_header(16'($urandom), PROTOCOL_MODBUS, 8'($urandom));
                put_junk($urandom_range(0, 8));
            end else if (kind < 80) begin
                put_header(16'($urandom), 16'($urandom_range(1, 65535)),
                           ($urandom_range(0, 1) != 0) ? WRITE_SINGLE : 8'($urandom));
                put_junk($urandom_range(0, 8));
            end else if (kind < 90) begin
                put_junk($urandom_range(1, 7));
            end else begin
                put_header(16'($urandom), PROTOCOL_MODBUS, WRITE_SINGLE);
                put_junk($urandom_range(0, 3));
            end
            send_frame();
        end
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("no transfer for %0d cycles", STALL_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        int unsigned gap;
        wait (rst_n);
        forever begin
            gap = pick_gap(rx_burst);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    initial begin
        int unsigned phase_end;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed frames under the reset register values.
        tx_burst = 1'b1;
        frame_q.push_back(8'hFF);
        send_frame();
        put_junk(0);
        repeat (7) frame_q.push_back(8'h00);
        send_frame();
        repeat (8) frame_q.push_back(8'hFF);
        send_frame();
        tx_burst = 1'b0;
        put_header(16'h0000, PROTOCOL_MODBUS, 8'h03);
        send_frame();
        put_header(16'h1234, PROTOCOL_MODBUS, WRITE_SINGLE);
        put_junk(3);
        send_frame();
        put_write(16'hFFFF, WATCHED_RESET, CEILING_RESET, 0);
        put_write(16'h0001, WATCHED_RESET, CEILING_RESET + 16'd1, 0);
        tx_burst = 1'b1;
        rx_burst = 1'b1;
        put_write(16'h8000, WATCHED_RESET, 16'hFFFF, 8);
        put_write(16'h7FFF, WATCHED_RESET + 16'd1, 16'hFFFF, 0);
        put_header(16'hA5A5, 16'h0001, WRITE_SINGLE);
        put_word(WATCHED_RESET);
        put_word(16'hFFFF);
        send_frame();
        rx_burst = 1'b0;

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: reconfigure(16'h0000, 16'h0000, 1'b0);
                1: reconfigure(16'hFFFF, 16'hFFFF, 1'b1);
                2: reconfigure(16'($urandom), 16'($urandom), 1'b0);
                3: reconfigure(16'($urandom), 16'h0000, 1'b1);
                default: reconfigure(WATCHED_RESET, 16'($urandom), 1'b0);
            endcase
            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end)
                random_frame();
        end

        settle();
        $display("Sent %0d bytes in %0d frames under six register settings.",
                 bytes_sent, frames_sent);
        $display("Checked %0d frame reports, %0d of them suspicious writes.",
                 audit_checked, audit_flagged);
        if (audit_mismatches == 0 && audit_outstanding == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
